/* hw/rtl/wuo_pkg.sv */
// Shared types, register codes and constants of the weight update optimizer.
package wuo_pkg;

  localparam int unsigned WUO_ENTRIES = 4096;
  localparam int unsigned INDEX_W     = 12;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned COEF_W      = 31;
  localparam int unsigned CFG_W       = 31;
  localparam int unsigned REG_INDEX_W = 3;

  typedef enum logic {
    OP_LOAD,
    OP_UPDATE
  } op_t;

  typedef enum logic [1:0] {
    METHOD_MOMENTUM,
    METHOD_L2,
    METHOD_DECOUPLED,
    METHOD_RPROP
  } method_t;

  localparam logic [REG_INDEX_W-1:0] REG_METHOD     = REG_INDEX_W'(0);
  localparam logic [REG_INDEX_W-1:0] REG_RATE       = REG_INDEX_W'(1);
  localparam logic [REG_INDEX_W-1:0] REG_MOMENTUM   = REG_INDEX_W'(2);
  localparam logic [REG_INDEX_W-1:0] REG_DECAY_COEF = REG_INDEX_W'(3);
  localparam logic [REG_INDEX_W-1:0] REG_GROW       = REG_INDEX_W'(4);
  localparam logic [REG_INDEX_W-1:0] REG_SHRINK     = REG_INDEX_W'(5);
  localparam logic [REG_INDEX_W-1:0] REG_STEP_MIN   = REG_INDEX_W'(6);
  localparam logic [REG_INDEX_W-1:0] REG_STEP_MAX   = REG_INDEX_W'(7);

  // Reset values, Q7.24.
  localparam logic [COEF_W-1:0] RST_RATE       = COEF_W'(16777);
  localparam logic [COEF_W-1:0] RST_MOMENTUM   = COEF_W'(0);
  localparam logic [COEF_W-1:0] RST_DECAY_COEF = COEF_W'(0);
  localparam logic [COEF_W-1:0] RST_GROW       = COEF_W'(18454938);
  localparam logic [COEF_W-1:0] RST_SHRINK     = COEF_W'(10066330);
  localparam logic [COEF_W-1:0] RST_STEP_MIN   = COEF_W'(1678);
  localparam logic [COEF_W-1:0] RST_STEP_MAX   = COEF_W'(16777);

  typedef struct packed {
    op_t                      op;
    logic [INDEX_W-1:0]       index;
    logic signed [DATA_W-1:0] load_weight;
    logic signed [DATA_W-1:0] load_step;
    logic signed [DATA_W-1:0] gradient;
  } item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]       out_index;
    logic signed [DATA_W-1:0] new_weight;
    logic signed [DATA_W-1:0] new_step;
  } result_t;

  // One memory word per entry: weight, step and last gradient.
  typedef struct packed {
    logic signed [DATA_W-1:0] weight;
    logic signed [DATA_W-1:0] step;
    logic signed [DATA_W-1:0] grad;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

/* hw/rtl/wuo_ram.sv */
// Generic single-clock RAM, one write port and one registered read port.
module wuo_ram
  import wuo_pkg::*;
#(
  parameter int unsigned WIDTH = ENTRY_W,
  parameter int unsigned DEPTH = WUO_ENTRIES
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/weight_update_optimizer_unit.sv */
// Top level of the per-entry weight update optimizer (momentum descent, decay, RProp-).
//
// Usage:
//   item channel (item_valid / item_stall / item): one beat is a load (weight and step
//   written, old gradient cleared) or an update (gradient applied with the configured
//   method). The index is reduced modulo ENTRIES.
//   result channel (result_valid / result_stall / result): exactly one beat per item,
//   in item order, carrying the entry index and its new weight and step.
//   cfg port (cfg_write / cfg_index / cfg_data): register writes, which the user must
//   make only while no item is in flight; the block itself does not enforce it.
// Path: an accepted item moves through S1 to S6 and then into the result register.
// Throughput: one item per cycle, unless a result stall or an entry hazard holds it.
//   All state lives in one RAM word per entry, read at the second stage and written
//   back at the last, so an item whose entry is still in flight waits at the first
//   stage until that write lands, as back-to-back items on the same entry do.
// Reset: clears the pipeline and the result register and loads the register defaults;
//   the RAM is not cleared, so every entry must be loaded before it is updated.
// Stall: a stalled result holds in the output register; stages behind it keep moving
//   until they fill, so items are still taken while bubbles remain in the pipeline.
module weight_update_optimizer_unit
  import wuo_pkg::*;
#(
  parameter int unsigned ENTRIES = WUO_ENTRIES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result,
  input  logic                   cfg_write,
  input  logic [REG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam logic [31:0] ENT_W32 = 32'(ENTRIES);
  // ceil(2^32 / ENTRIES): exact quotient for any 12-bit index
  localparam logic [31:0] RECIP =
    32'(((64'd1 << 32) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES));

  typedef struct packed {
    op_t                      op;
    logic [IDX_W-1:0]         addr;
    logic signed [DATA_W-1:0] grad;
  } tag_t;

  // ---------------------------------------------------------------------------
  // Arithmetic helpers
  // ---------------------------------------------------------------------------
  // Unsigned Q7.24 coefficient times signed Q8.24 value, full product.
  function automatic logic signed [63:0] cmul(input logic [COEF_W-1:0] c,
                                              input logic signed [DATA_W-1:0] v);
    logic signed [63:0] p;
    p = 64'($signed({1'b0, c})) * 64'(v);
    return p;
  endfunction

  // Round half up and drop 24 fraction bits.
  function automatic logic signed [39:0] q_round(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd8388608;
    return t[63:24];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
    logic signed [31:0] r;
    if (x > 48'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -48'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  method_t           method;
  logic [COEF_W-1:0] rate;
  logic [COEF_W-1:0] momentum;
  logic [COEF_W-1:0] decay_coef;
  logic [COEF_W-1:0] grow_factor;
  logic [COEF_W-1:0] shrink_factor;
  logic [COEF_W-1:0] step_min;
  logic [COEF_W-1:0] step_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      method        <= METHOD_MOMENTUM;
      rate          <= RST_RATE;
      momentum      <= RST_MOMENTUM;
      decay_coef    <= RST_DECAY_COEF;
      grow_factor   <= RST_GROW;
      shrink_factor <= RST_SHRINK;
      step_min      <= RST_STEP_MIN;
      step_max      <= RST_STEP_MAX;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_METHOD:     method        <= method_t'(cfg_data[1:0]);
        REG_RATE:       rate          <= cfg_data;
        REG_MOMENTUM:   momentum      <= cfg_data;
        REG_DECAY_COEF: decay_coef    <= cfg_data;
        REG_GROW:       grow_factor   <= cfg_data;
        REG_SHRINK:     shrink_factor <= cfg_data;
        REG_STEP_MIN:   step_min      <= cfg_data;
        REG_STEP_MAX:   step_max      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline registers
  // ---------------------------------------------------------------------------
  // S1: accepted item plus index quotient
  logic                      s1_valid;
  item_t                     s1_item;
  logic [INDEX_W-1:0]        s1_quot;
  // S2: RAM read data arrives here, multipliers run
  logic                      s2_valid;
  tag_t                      s2_tag;
  logic signed [DATA_W-1:0]  s2_load_w;
  logic signed [DATA_W-1:0]  s2_load_s;
  // S3: round, sum, saturate, clamp -> new step
  logic                      s3_valid;
  tag_t                      s3_tag;
  logic signed [DATA_W-1:0]  s3_w;
  logic signed [DATA_W-1:0]  s3_s;
  logic                      s3_scale;
  logic signed [63:0]        s3_pa;
  logic signed [63:0]        s3_pr;
  logic signed [63:0]        s3_pd;
  // S4: weight minus or plus step
  logic                      s4_valid;
  tag_t                      s4_tag;
  logic signed [DATA_W-1:0]  s4_w;
  logic signed [DATA_W-1:0]  s4_step;
  // S5: decoupled decay product
  logic                      s5_valid;
  tag_t                      s5_tag;
  logic signed [DATA_W-1:0]  s5_wa;
  logic signed [DATA_W-1:0]  s5_step;
  // S6: final weight, write back
  logic                      s6_valid;
  tag_t                      s6_tag;
  logic signed [DATA_W-1:0]  s6_wa;
  logic signed [DATA_W-1:0]  s6_step;
  logic signed [63:0]        s6_pd;

  // ---------------------------------------------------------------------------
  // Flow control: each stage advances when the one ahead is empty or leaving
  // ---------------------------------------------------------------------------
  logic out_free;
  logic mv1, mv2, mv3, mv4, mv5, mv6;
  logic free1, free2, free3, free4, free5, free6;
  logic hazard;
  logic item_take;

  assign out_free = !result_valid || !result_stall;
  assign mv6   = s6_valid && out_free;
  assign free6 = !s6_valid || mv6;
  assign mv5   = s5_valid && free6;
  assign free5 = !s5_valid || mv5;
  assign mv4   = s4_valid && free5;
  assign free4 = !s4_valid || mv4;
  assign mv3   = s3_valid && free4;
  assign free3 = !s3_valid || mv3;
  assign mv2   = s2_valid && free3;
  assign free2 = !s2_valid || mv2;
  // Hold the item at S1 while its entry is still on the way to write back.
  assign mv1   = s1_valid && free2 && !hazard;
  assign free1 = !s1_valid || mv1;

  assign item_stall = !free1;
  assign item_take  = item_valid && free1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      s5_valid     <= 1'b0;
      s6_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (free1) begin
        s1_valid <= item_valid;
      end
      if (free2) begin
        s2_valid <= mv1;
      end
      if (free3) begin
        s3_valid <= mv2;
      end
      if (free4) begin
        s4_valid <= mv3;
      end
      if (free5) begin
        s5_valid <= mv4;
      end
      if (free6) begin
        s6_valid <= mv5;
      end
      if (out_free) begin
        result_valid <= mv6;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // S1: reduce the index modulo ENTRIES, check for a pending write to it
  // ---------------------------------------------------------------------------
  logic [43:0]        in_prod;
  logic [43:0]        s1_qn;
  logic [INDEX_W-1:0] s1_rem;
  logic [IDX_W-1:0]   s1_addr;

  assign in_prod = {32'd0, item.index} * {12'd0, RECIP};
  assign s1_qn   = {32'd0, s1_quot} * {12'd0, ENT_W32};
  assign s1_rem  = s1_item.index - s1_qn[INDEX_W-1:0];
  assign s1_addr = IDX_W'(s1_rem);

  assign hazard = (s2_valid && s2_tag.addr == s1_addr) ||
                  (s3_valid && s3_tag.addr == s1_addr) ||
                  (s4_valid && s4_tag.addr == s1_addr) ||
                  (s5_valid && s5_tag.addr == s1_addr) ||
                  (s6_valid && s6_tag.addr == s1_addr);

  // ---------------------------------------------------------------------------
  // Entry memory
  // ---------------------------------------------------------------------------
  entry_t rd_entry;
  entry_t wr_entry;

  wuo_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mv6),
    .wr_addr (s6_tag.addr),
    .wr_data (wr_entry),
    .rd_en   (mv1),
    .rd_addr (s1_addr),
    .rd_data (rd_entry)
  );

  // ---------------------------------------------------------------------------
  // S2: products. RProp- shares the momentum multiplier for its step scaling.
  // ---------------------------------------------------------------------------
  logic              s2_same;
  logic              s2_diff;
  logic              s2_nonzero;
  logic [COEF_W-1:0] s2_coef_a;
  logic signed [63:0] s2_pa;
  logic signed [63:0] s2_pr;
  logic signed [63:0] s2_pd;

  assign s2_nonzero = (s2_tag.grad != '0) && (rd_entry.grad != '0);
  assign s2_same    = s2_nonzero && (s2_tag.grad[DATA_W-1] == rd_entry.grad[DATA_W-1]);
  assign s2_diff    = s2_nonzero && (s2_tag.grad[DATA_W-1] != rd_entry.grad[DATA_W-1]);
  assign s2_coef_a  = (method == METHOD_RPROP) ? (s2_same ? grow_factor : shrink_factor)
                                               : momentum;
  assign s2_pa = cmul(s2_coef_a, rd_entry.step);
  assign s2_pr = cmul(rate, s2_tag.grad);
  assign s2_pd = cmul(decay_coef, rd_entry.weight);

  // ---------------------------------------------------------------------------
  // S3: new step
  // ---------------------------------------------------------------------------
  logic signed [39:0]       s3_qa;
  logic signed [39:0]       s3_qr;
  logic signed [39:0]       s3_qd;
  logic signed [41:0]       s3_acc;
  logic signed [DATA_W-1:0] s3_rp;
  logic signed [DATA_W-1:0] s3_clamped;
  logic signed [DATA_W-1:0] s3_step_new;
  logic signed [DATA_W-1:0] s3_max;
  logic signed [DATA_W-1:0] s3_min;

  assign s3_qa  = q_round(s3_pa);
  assign s3_qr  = q_round(s3_pr);
  assign s3_qd  = q_round(s3_pd);
  assign s3_acc = 42'(s3_qa) + 42'(s3_qr) + ((method == METHOD_L2) ? 42'(s3_qd) : 42'sd0);
  assign s3_max = $signed({1'b0, step_max});
  assign s3_min = $signed({1'b0, step_min});
  assign s3_rp  = s3_scale ? sat32(48'(s3_qa)) : s3_s;

  always_comb begin
    // The max bound is checked first: with crossed bounds, above max gives max, else min.
    if (s3_rp > s3_max) begin
      s3_clamped = s3_max;
    end else if (s3_rp < s3_min) begin
      s3_clamped = s3_min;
    end else begin
      s3_clamped = s3_rp;
    end
    if (s3_tag.op == OP_LOAD) begin
      s3_step_new = s3_s;
    end else if (method == METHOD_RPROP) begin
      s3_step_new = s3_clamped;
    end else begin
      s3_step_new = sat32(48'(s3_acc));
    end
  end

  // ---------------------------------------------------------------------------
  // S4: weight moved by the step
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0] s4_w_dn;
  logic signed [DATA_W-1:0] s4_w_up;
  logic signed [DATA_W-1:0] s4_wa;
  logic                     s4_g_pos;
  logic                     s4_g_neg;

  assign s4_w_dn  = sat32(48'(33'(s4_w) - 33'(s4_step)));
  assign s4_w_up  = sat32(48'(33'(s4_w) + 33'(s4_step)));
  assign s4_g_neg = s4_tag.grad[DATA_W-1];
  assign s4_g_pos = !s4_g_neg && (s4_tag.grad != '0);

  always_comb begin
    if (s4_tag.op == OP_LOAD) begin
      s4_wa = s4_w;
    end else if (method == METHOD_RPROP) begin
      if (s4_g_pos) begin
        s4_wa = s4_w_dn;
      end else if (s4_g_neg) begin
        s4_wa = s4_w_up;
      end else begin
        s4_wa = s4_w;
      end
    end else begin
      s4_wa = s4_w_dn;
    end
  end

  // ---------------------------------------------------------------------------
  // S5 / S6: decoupled decay on the updated weight, then write back
  // ---------------------------------------------------------------------------
  logic signed [63:0]       s5_pd;
  logic signed [DATA_W-1:0] s6_w_final;

  assign s5_pd = cmul(decay_coef, s5_wa);
  assign s6_w_final = (s6_tag.op == OP_UPDATE && method == METHOD_DECOUPLED)
                    ? sat32(48'(41'(s6_wa) - 41'(q_round(s6_pd))))
                    : s6_wa;

  assign wr_entry.weight = s6_w_final;
  assign wr_entry.step   = s6_step;
  assign wr_entry.grad   = s6_tag.grad;

  // ---------------------------------------------------------------------------
  // Payload registers: advance with their stage, no reset
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (item_take) begin
      s1_item <= item;
      s1_quot <= in_prod[43:32];
    end
    if (mv1) begin
      s2_tag.op   <= s1_item.op;
      s2_tag.addr <= s1_addr;
      // A load clears the stored gradient.
      s2_tag.grad <= (s1_item.op == OP_UPDATE) ? s1_item.gradient : '0;
      s2_load_w   <= s1_item.load_weight;
      s2_load_s   <= s1_item.load_step;
    end
    if (mv2) begin
      s3_tag   <= s2_tag;
      s3_w     <= (s2_tag.op == OP_LOAD) ? s2_load_w : rd_entry.weight;
      s3_s     <= (s2_tag.op == OP_LOAD) ? s2_load_s : rd_entry.step;
      s3_scale <= s2_same || s2_diff;
      s3_pa    <= s2_pa;
      s3_pr    <= s2_pr;
      s3_pd    <= s2_pd;
    end
    if (mv3) begin
      s4_tag  <= s3_tag;
      s4_w    <= s3_w;
      s4_step <= s3_step_new;
    end
    if (mv4) begin
      s5_tag  <= s4_tag;
      s5_wa   <= s4_wa;
      s5_step <= s4_step;
    end
    if (mv5) begin
      s6_tag  <= s5_tag;
      s6_wa   <= s5_wa;
      s6_step <= s5_step;
      s6_pd   <= s5_pd;
    end
    if (mv6) begin
      result.out_index  <= INDEX_W'(s6_tag.addr);
      result.new_weight <= s6_w_final;
      result.new_step   <= s6_step;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The interlock keeps every entry at most once between read and write back.
  assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> !((s3_valid && s3_tag.addr == s2_tag.addr) ||
                   (s4_valid && s4_tag.addr == s2_tag.addr) ||
                   (s5_valid && s5_tag.addr == s2_tag.addr) ||
                   (s6_valid && s6_tag.addr == s2_tag.addr)))
    else $error("entry in flight twice between read and write back");

  // An empty first stage never refuses an item.
  assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !item_stall)
    else $error("item refused with an empty first stage");

  // An accepted beat lands in the first stage.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> s1_valid)
    else $error("accepted item lost at the first stage");

  // A write back always loads the result register.
  assert property (@(posedge clk) disable iff (rst)
    mv6 |=> result_valid && result.out_index == INDEX_W'($past(s6_tag.addr)))
    else $error("write back without matching result");

  // Reset leaves no result pending.
  assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

endmodule

/* dv/weight_update_optimizer_unit_test.sv */
// Self-checking testbench for the weight update optimizer: directed and random beats.
`timescale 1ns / 1ps

module weight_update_optimizer_unit_test;
  import wuo_pkg::*;

  // Shadow of the entry stores and the register file. Each accepted item beat
  // yields the one result beat it must cause; result beats are matched in order.
  class optimizer_mirror;
    logic signed [DATA_W-1:0] weight_mem [WUO_ENTRIES];
    logic signed [DATA_W-1:0] step_mem [WUO_ENTRIES];
    logic signed [DATA_W-1:0] grad_mem [WUO_ENTRIES];
    method_t method;
    longint rate, momentum, decay_coef, grow, shrink, step_min, step_max;
    result_t due_results [$];
    int mismatches;

    function new();
      method     = METHOD_MOMENTUM;
      rate       = longint'(RST_RATE);
      momentum   = longint'(RST_MOMENTUM);
      decay_coef = longint'(RST_DECAY_COEF);
      grow       = longint'(RST_GROW);
      shrink     = longint'(RST_SHRINK);
      step_min   = longint'(RST_STEP_MIN);
      step_max   = longint'(RST_STEP_MAX);
      mismatches = 0;
    endfunction

    // Q8.24 product, rounded half up.
    function longint q_mul(longint a, longint b);
      return (a * b + 64'sd8388608) >>> 24;
    endfunction

    function logic signed [DATA_W-1:0] clip32(longint x);
      if (x > 64'sd2147483647) return 32'sh7fffffff;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return x[DATA_W-1:0];
    endfunction

    function int sign_of(longint x);
      if (x > 0) return 1;
      if (x < 0) return -1;
      return 0;
    endfunction

    function void set_reg(logic [REG_INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_METHOD:     method = method_t'(val[1:0]);
        REG_RATE:       rate = longint'(val);
        REG_MOMENTUM:   momentum = longint'(val);
        REG_DECAY_COEF: decay_coef = longint'(val);
        REG_GROW:       grow = longint'(val);
        REG_SHRINK:     shrink = longint'(val);
        REG_STEP_MIN:   step_min = longint'(val);
        REG_STEP_MAX:   step_max = longint'(val);
        default: ;
      endcase
    endfunction

    function void accept_item(item_t it);
      int unsigned slot;
      longint w, s, g, g_old, acc, w1;
      int prod;
      logic signed [DATA_W-1:0] w_n, s_n;
      result_t r;
      slot = it.index % WUO_ENTRIES;
      if (it.op == OP_LOAD) begin
        w_n = it.load_weight;
        s_n = it.load_step;
        grad_mem[slot] = '0;
      end else begin
        w = longint'(weight_mem[slot]);
        s = longint'(step_mem[slot]);
        g = longint'(it.gradient);
        g_old = longint'(grad_mem[slot]);
        if (method == METHOD_RPROP) begin
          prod = sign_of(g) * sign_of(g_old);
          if (prod > 0) s = longint'(clip32(q_mul(grow, s)));
          else if (prod < 0) s = longint'(clip32(q_mul(shrink, s)));
          // max bound checked first: with crossed bounds, above max gives max, else min
          if (s > step_max) s = step_max;
          else if (s < step_min) s = step_min;
          s_n = s[DATA_W-1:0];
          if (g > 0) w_n = clip32(w - s);
          else if (g < 0) w_n = clip32(w + s);
          else w_n = w[DATA_W-1:0];
        end else begin
          acc = q_mul(momentum, s) + q_mul(rate, g);
          if (method == METHOD_L2) acc += q_mul(decay_coef, w);
          s_n = clip32(acc);
          w1 = longint'(clip32(w - longint'(s_n)));
          if (method == METHOD_DECOUPLED)
            w1 = longint'(clip32(w1 - q_mul(decay_coef, w1)));
          w_n = w1[DATA_W-1:0];
        end
        grad_mem[slot] = it.gradient;
      end
      weight_mem[slot] = w_n;
      step_mem[slot] = s_n;
      r.out_index = INDEX_W'(slot);
      r.new_weight = w_n;
      r.new_step = s_n;
      due_results = {due_results, r};
    endfunction

    function void match_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result beat: index %0d weight %0d step %0d",
                 $time, got.out_index, got.new_weight, got.new_step);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      if (got.out_index !== want.out_index) begin
        $display("%0t: out_index expected %0d actual %0d", $time, want.out_index, got.out_index);
        mismatches++;
      end
      if (got.new_weight !== want.new_weight) begin
        $display("%0t: new_weight (index %0d) expected %0d actual %0d",
                 $time, want.out_index, want.new_weight, got.new_weight);
        mismatches++;
      end
      if (got.new_step !== want.new_step) begin
        $display("%0t: new_step (index %0d) expected %0d actual %0d",
                 $time, want.out_index, want.new_step, got.new_step);
        mismatches++;
      end
    endfunction
  endclass

  localparam int PHASES = 8;
  localparam int PHASE_BEATS = 180;
  localparam int HOLD_CYCLES = 120;
  localparam int HOT_N = 8;
  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0100_0000;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  item_t item;
  logic result_valid;
  logic result_stall;
  result_t result;
  logic cfg_write;
  logic [REG_INDEX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  optimizer_mirror sb = new();

  // steady: no idling on either side; hold_req: ask the receiver for a long hold-off
  bit steady = 1'b0;
  bit hold_req = 1'b0;

  // Entries that have been loaded at least once; only these get updates.
  bit loaded [WUO_ENTRIES];
  int unsigned loaded_list [$];
  // A few entries hit again and again, so RProp sees long sign histories and
  // back-to-back beats on the same entry exercise the in-flight hazard.
  int unsigned hot_entries [HOT_N] = '{0, 1, 2, 3, 100, 2047, 2048, 4095};
  method_t method_order [4] = '{METHOD_MOMENTUM, METHOD_L2, METHOD_DECOUPLED, METHOD_RPROP};

  weight_update_optimizer_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4_000_000;
    $display("weight_update_optimizer_unit verification failed");
    $finish;
  end

  // Receiver: random stalls, a long counted hold-off on request, none while steady.
  initial begin
    int hold_left;
    hold_left = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !steady && ($urandom_range(99) < 16);
      end
    end
  end

  // Monitor: check every accepted result beat. Values seen here are pre-edge.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.match_result(result);
  end

  function automatic logic signed [DATA_W-1:0] rand_word();
    case ($urandom_range(9))
      0: return '0;
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      3: return $urandom_range(1) ? 32'sd1 : -32'sd1;
      4, 5, 6: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_step();
    if ($urandom_range(1)) return $urandom_range(0, 1 << 20);
    return rand_word();
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_grad();
    if ($urandom_range(99) < 12) return '0;
    return rand_word();
  endfunction

  function automatic logic [CFG_W-1:0] rand_coef();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2, 3, 4: return CFG_W'($urandom_range(0, 32'h0200_0000));
      5: return CFG_W'($urandom_range(0, 1 << 20));
      default: return CFG_W'($urandom());
    endcase
  endfunction

  function automatic item_t mk_load(int unsigned idx, logic signed [DATA_W-1:0] w,
                                    logic signed [DATA_W-1:0] s);
    item_t it;
    it.op = OP_LOAD;
    it.index = INDEX_W'(idx);
    it.load_weight = w;
    it.load_step = s;
    it.gradient = $urandom();
    return it;
  endfunction

  function automatic item_t mk_update(int unsigned idx, logic signed [DATA_W-1:0] g);
    item_t it;
    it.op = OP_UPDATE;
    it.index = INDEX_W'(idx);
    it.load_weight = $urandom();
    it.load_step = $urandom();
    it.gradient = g;
    return it;
  endfunction

  // Mostly hot entries, then other loaded ones, then fresh entries (which must load first).
  function automatic item_t random_item();
    int unsigned idx;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) idx = hot_entries[$urandom_range(HOT_N - 1)];
    else if (roll < 80 && loaded_list.size() != 0)
      idx = loaded_list[$urandom_range(loaded_list.size() - 1)];
    else idx = $urandom_range(WUO_ENTRIES - 1);
    if (!loaded[idx] || $urandom_range(99) < 18) return mk_load(idx, rand_word(), rand_step());
    return mk_update(idx, rand_grad());
  endfunction

  // Offer one item beat, with random idle cycles ahead of it, and hold it until taken.
  task automatic offer(input item_t it);
    while (!steady && $urandom_range(99) < 16) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    sb.accept_item(it);
    if (it.op == OP_LOAD && !loaded[it.index]) begin
      loaded[it.index] = 1'b1;
      loaded_list = {loaded_list, 32'(it.index)};
    end
  endtask

  // Drop valid and wait until every due result beat has come back.
  task automatic drain();
    item_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
  endtask

  // One register write per edge; the caller lowers cfg_write after the batch.
  task automatic write_reg(input logic [REG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic run_directed();
    // Reset settings: momentum descent, momentum 0. Saturate both ways at the
    // extremes of weight and gradient, on the first and last entries.
    offer(mk_load(0, 32'sh7fffffff, Q_ONE));
    offer(mk_load(4095, 32'sh80000000, -32'sd1));
    offer(mk_load(5, '0, '0));
    offer(mk_update(0, 32'sh80000000));
    offer(mk_update(4095, 32'sh7fffffff));
    drain();
    // L2 decay with momentum 0.9 and decay 0.1
    write_reg(REG_METHOD, CFG_W'(METHOD_L2));
    write_reg(REG_MOMENTUM, CFG_W'(15099494));
    write_reg(REG_DECAY_COEF, CFG_W'(1677722));
    cfg_write <= 1'b0;
    offer(mk_update(5, Q_ONE));
    offer(mk_update(0, -Q_ONE));
    drain();
    // decoupled decay at the largest coefficient
    write_reg(REG_METHOD, CFG_W'(METHOD_DECOUPLED));
    write_reg(REG_DECAY_COEF, '1);
    cfg_write <= 1'b0;
    offer(mk_update(4095, '0));
    offer(mk_update(5, 32'sh0080_0000));
    drain();
    // RProp- with reset factors: first gradient after load (old gradient zero),
    // same sign, sign change, zero gradient, then again after a zero.
    write_reg(REG_METHOD, CFG_W'(METHOD_RPROP));
    cfg_write <= 1'b0;
    offer(mk_load(7, '0, 32'sd1000));
    offer(mk_update(7, 32'sd1));
    offer(mk_update(7, 32'sd5));
    offer(mk_update(7, -32'sd3));
    offer(mk_update(7, '0));
    offer(mk_update(7, 32'sd1));
    // negative step is raised to step_min by the clamp
    offer(mk_load(8, 32'sd100, -32'sd5000000));
    offer(mk_update(8, -32'sd1));
    drain();
    // crossed bounds: max test first, then min
    write_reg(REG_STEP_MIN, CFG_W'(20000000));
    write_reg(REG_STEP_MAX, CFG_W'(100));
    cfg_write <= 1'b0;
    offer(mk_load(9, '0, Q_ONE));
    offer(mk_update(9, 32'sd2));
    offer(mk_load(10, '0, 32'sd50));
    offer(mk_update(10, -32'sd2));
  endtask

  // Write all registers for phase p: all zeros once, all ones once, RProp with
  // sane bounds, and crossed bounds in the last RProp phase.
  task automatic configure_phase(input int p);
    logic [CFG_W-1:0] val [8];
    logic [CFG_W-1:0] tmp;
    method_t pick;
    int k;
    pick = method_order[p % 4];
    for (k = 0; k < 8; k++) val[k] = rand_coef();
    if (p == 1) begin
      for (k = 0; k < 8; k++) val[k] = '0;
    end else if (p == 2) begin
      for (k = 0; k < 8; k++) val[k] = '1;
    end else if (pick == METHOD_RPROP) begin
      val[REG_GROW] = CFG_W'($urandom_range(32'h0100_0000, 32'h0200_0000));
      val[REG_SHRINK] = CFG_W'($urandom_range(0, 32'h0100_0000));
      val[REG_STEP_MIN] = CFG_W'($urandom_range(0, 1 << 16));
      val[REG_STEP_MAX] = CFG_W'($urandom_range(1 << 16, 1 << 26));
      if (p == PHASES - 1) begin
        tmp = val[REG_STEP_MIN];
        val[REG_STEP_MIN] = val[REG_STEP_MAX];
        val[REG_STEP_MAX] = tmp;
      end
    end
    val[REG_METHOD] = CFG_W'(pick);
    for (k = 0; k < 8; k++) write_reg(REG_INDEX_W'(k), val[k]);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int p;
    int n;
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    run_directed();

    for (p = 0; p < PHASES; p++) begin
      // registers change only with the pipeline empty
      drain();
      configure_phase(p);
      steady = (p == 4);
      for (n = 0; n < PHASE_BEATS; n++) begin
        // hold off the receiver while beats keep coming, so the block backs up
        if (n == 60 && !steady) hold_req = 1'b1;
        // pause the sender until all due results are back
        if (n == 120) drain();
        offer(random_item());
      end
    end

    drain();
    steady = 1'b0;
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("weight_update_optimizer_unit verification clean");
    end else begin
      $display("weight_update_optimizer_unit verification failed");
    end
    $finish;
  end

endmodule
